// ===== rtl/lsf_pkg.sv =====
`default_nettype none
package lsf_pkg;

	localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0]  NUL_BYTE     = 8'h00;
	localparam logic [11:0] LENGTH_MAX   = 12'd4095;

	// Configuration register indexes.
	localparam logic [2:0] REG_PAT_LO     = 3'd0;
	localparam logic [2:0] REG_PAT_MID_LO = 3'd1;
	localparam logic [2:0] REG_PAT_MID_HI = 3'd2;
	localparam logic [2:0] REG_PAT_HI     = 3'd3;
	localparam logic [2:0] REG_PAT_LEN    = 3'd4;
	localparam logic [2:0] REG_FOLD_CASE  = 3'd5;
	localparam logic [2:0] REG_INVERT     = 3'd6;

	// Stored pattern bytes, byte 0 in the low bits.
	localparam int PAT_STORE_BYTES = 32;

	typedef logic [PAT_STORE_BYTES*8-1:0] pat_store_t;

	// Only A-Z are folded, and only when folding is switched on.
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
		logic [7:0] r;
		r = b;
		if (en && b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/line_substring_filter_top.sv =====
// A word is registered in the input stage, then its result in the result register.
// One byte per cycle when out_ready keeps up; the shift-and update is one registered step.
// A line is reported on its newline, or at end of file when an unterminated line is pending.
// Reset (arst_n low, asynchronous) clears the configuration, the line state, the line
// counter and both valid flags.
`default_nettype none
module line_substring_filter_top
	import lsf_pkg::*;
#(
	parameter int MAX_PATTERN = 32,
	parameter int LINE_LIMIT  = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_file,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      line_number,
	output logic [11:0]      line_length,
	output logic             selected
);

	localparam int CW = (LINE_LIMIT > 2) ? $clog2(LINE_LIMIT) : 1;
	localparam logic [CW-1:0] STORE_MAX = CW'(LINE_LIMIT - 1);

	// Configuration registers
	pat_store_t  pat_q;
	logic [5:0]  plen_q;
	logic        fold_q;
	logic        invert_q;

	// Line state
	logic [MAX_PATTERN-1:0] hits_q;
	logic                   found_q;
	logic                   nul_q;
	logic [CW-1:0]          stored_q;
	logic [31:0]            ctr_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eof_s1;

	// Result register
	logic        out_valid_q;
	logic [31:0] number_q;
	logic [11:0] length_q;
	logic        sel_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q    <= '0;
			plen_q   <= '0;
			fold_q   <= 1'b0;
			invert_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PAT_LO:     pat_q[63:0]    <= cfg_data;
				REG_PAT_MID_LO: pat_q[127:64]  <= cfg_data;
				REG_PAT_MID_HI: pat_q[191:128] <= cfg_data;
				REG_PAT_HI:     pat_q[255:192] <= cfg_data;
				REG_PAT_LEN:    plen_q         <= cfg_data[5:0];
				REG_FOLD_CASE:  fold_q         <= cfg_data[0];
				REG_INVERT:     invert_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pattern length in use, limited to the number of lanes.
	logic [6:0] plen_eff;
	assign plen_eff = (7'(plen_q) > 7'(MAX_PATTERN)) ? 7'(MAX_PATTERN) : 7'(plen_q);

	logic [7:0]             byte_f;
	logic [MAX_PATTERN-1:0] eq;
	logic [MAX_PATTERN-1:0] top;

	assign byte_f = fold_byte(data_s1, fold_q);

	// One comparator lane per pattern position; lanes past the stored bytes see zero.
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
		logic [7:0] pb;
		if (k < PAT_STORE_BYTES) begin : g_stored
			assign pb = pat_q[k*8 +: 8];
		end else begin : g_zero
			assign pb = 8'h00;
		end
		assign eq[k]  = (7'(k) < plen_eff) && (fold_byte(pb, fold_q) == byte_f);
		assign top[k] = (7'(k + 1) == plen_eff);
	end

	logic                   advance;
	logic                   store;
	logic                   search;
	logic [CW-1:0]          stored_n;
	logic                   nul_n;
	logic [MAX_PATTERN-1:0] hits_n;
	logic                   found_n;
	logic                   is_nl;
	logic                   emit;
	logic [31:0]            ctr_inc;
	logic [31:0]            stored_w;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		store    = stored_q < STORE_MAX;
		stored_n = store ? stored_q + CW'(1) : stored_q;
		search   = store && !nul_q && data_s1 != NUL_BYTE && plen_eff != 7'd0;
		nul_n    = nul_q || (store && data_s1 == NUL_BYTE);
		hits_n   = search ? (((hits_q << 1) | MAX_PATTERN'(1)) & eq) : hits_q;
		found_n  = found_q || (search && |(hits_n & top));
		is_nl    = data_s1 == NEWLINE_BYTE;
		emit     = is_nl || (eof_s1 && stored_n != '0);
		ctr_inc  = (ctr_q == '1) ? ctr_q : ctr_q + 32'd1;
		stored_w = 32'(stored_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			found_q  <= 1'b0;
			nul_q    <= 1'b0;
			stored_q <= '0;
			ctr_q    <= '0;
		end else if (advance) begin
			if (emit || eof_s1) begin
				hits_q   <= '0;
				found_q  <= 1'b0;
				nul_q    <= 1'b0;
				stored_q <= '0;
			end else begin
				hits_q   <= hits_n;
				found_q  <= found_n;
				nul_q    <= nul_n;
				stored_q <= stored_n;
			end
			// Numbering restarts after the last word of a file.
			if (eof_s1) begin
				ctr_q <= '0;
			end else if (emit) begin
				ctr_q <= ctr_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			number_q <= ctr_inc;
			length_q <= (stored_w > 32'(LENGTH_MAX)) ? LENGTH_MAX : stored_w[11:0];
			sel_q    <= (found_n || plen_eff == 7'd0) ^ invert_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_number = number_q;
	assign line_length = length_q;
	assign selected    = sel_q;

	a_number_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != 32'd0)
		else $error("result carries line number zero");

	a_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_length != 12'd0)
		else $error("result carries an empty line");

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eof_s1 |=> ctr_q == 32'd0 && stored_q == '0)
		else $error("line state not restarted after end of file");

	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= STORE_MAX)
		else $error("stored count beyond line limit");

endmodule
`default_nettype wire

// ===== sim/tb_line_substring_filter_top.sv =====
`timescale 1ns / 100ps
module tb_line_substring_filter_top;
	import lsf_pkg::*;

	localparam int LINE_LIMIT     = 4096;
	localparam int PAT_MAX        = 32;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int PHASE_BYTES    = 205;

	typedef struct packed {
		logic [7:0] value;
		logic       eof;
	} text_byte_t;

	typedef struct packed {
		logic [31:0] num;
		logic [11:0] len;
		logic        sel;
	} line_rec_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic [2:0]  cfg_index   = '0;
	logic [63:0] cfg_data    = '0;
	logic        in_valid    = 1'b0;
	logic [7:0]  data_byte   = '0;
	logic        end_of_file = 1'b0;
	logic        out_ready   = 1'b0;
	logic        cfg_ready;
	logic        in_ready;
	logic        out_valid;
	logic [31:0] line_number;
	logic [11:0] line_length;
	logic        selected;

	line_substring_filter_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.end_of_file (end_of_file),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.line_number (line_number),
		.line_length (line_length),
		.selected    (selected)
	);

	always #5 clk = ~clk;

	text_byte_t  pending_items[$];
	line_rec_t   expected_lines[$];
	line_rec_t   head_line;
	bit          no_idle = 1'b0;
	int          error_count = 0;
	int          stall_cycles = 0;

	// Filter state as the block should hold it.
	logic [255:0] pat_store   = '0;
	logic [5:0]   pat_len_reg = '0;
	logic         fold_en     = 1'b0;
	logic         invert_en   = 1'b0;
	logic [31:0]  prefix_hits = '0;
	logic         found       = 1'b0;
	logic         nul_seen    = 1'b0;
	logic [11:0]  stored_count = '0;
	logic [31:0]  line_counter = '0;

	function automatic int active_len();
		return (pat_len_reg > PAT_MAX) ? PAT_MAX : int'(pat_len_reg);
	endfunction

	function automatic logic [7:0] lower_letter(input logic [7:0] b);
		if (fold_en && b >= "A" && b <= "Z") begin
			return b + 8'h20;
		end
		return b;
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] value);
		case (idx)
			REG_PAT_LO:     pat_store[63:0]    = value;
			REG_PAT_MID_LO: pat_store[127:64]  = value;
			REG_PAT_MID_HI: pat_store[191:128] = value;
			REG_PAT_HI:     pat_store[255:192] = value;
			REG_PAT_LEN:    pat_len_reg        = value[5:0];
			REG_FOLD_CASE:  fold_en            = value[0];
			REG_INVERT:     invert_en          = value[0];
			default: ;
		endcase
	endfunction

	function automatic void reset_line();
		prefix_hits  = '0;
		found        = 1'b0;
		nul_seen     = 1'b0;
		stored_count = '0;
	endfunction

	function automatic void close_line();
		line_rec_t r;
		if (line_counter != '1) begin
			line_counter++;
		end
		r.num = line_counter;
		r.len = stored_count;
		r.sel = (found || active_len() == 0) ^ invert_en;
		expected_lines.push_back(r);
		reset_line();
	endfunction

	function automatic void track_byte(input logic [7:0] b, input logic eof);
		int          plen;
		int          k;
		logic [31:0] eq;
		bit          reported;
		plen = active_len();
		reported = 1'b0;
		if (stored_count < LINE_LIMIT - 1) begin
			stored_count++;
			if (!nul_seen) begin
				if (b == NUL_BYTE) begin
					nul_seen = 1'b1;
				end else if (plen != 0) begin
					eq = '0;
					for (k = 0; k < plen; k++) begin
						if (lower_letter(pat_store[k*8 +: 8]) == lower_letter(b)) begin
							eq[k] = 1'b1;
						end
					end
					prefix_hits = ((prefix_hits << 1) | 32'd1) & eq;
					if (prefix_hits[plen-1]) begin
						found = 1'b1;
					end
				end
			end
		end
		if (b == NEWLINE_BYTE) begin
			close_line();
			reported = 1'b1;
		end
		if (eof) begin
			if (!reported && stored_count != 0) begin
				close_line();
			end
			reset_line();
			line_counter = '0;
		end
	endfunction

	function automatic void send_byte(input logic [7:0] b, input logic eof);
		text_byte_t t;
		t.value = b;
		t.eof   = eof;
		pending_items.push_back(t);
	endfunction

	function automatic void send_text(input string s, input bit eof_last);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_byte(s[i], eof_last && i == s.len() - 1);
		end
	endfunction

	function automatic logic [7:0] vary_case(input logic [7:0] b, input bit en);
		if (en && $urandom_range(1) == 1 &&
				((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))) begin
			return b ^ 8'h20;
		end
		return b;
	endfunction

	// Queues one line of text and returns the number of bytes queued. Most lines are
	// built from pattern pieces so that matches and near misses are frequent.
	function automatic int queue_line();
		logic [7:0] text[$];
		int         plen;
		int         n;
		int         i;
		int         j;
		int         pick;
		int         cut;
		int         ending;
		bit         noise;
		bit         flip;
		plen  = active_len();
		noise = ($urandom_range(9) == 0);
		n = ($urandom_range(15) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 24);
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			flip = ($urandom_range(3) == 0);
			if (noise || pick < 4) begin
				text.push_back(8'($urandom_range(255)));
			end else if (pick == 4) begin
				text.push_back(NUL_BYTE);
			end else if (pick < 16 && plen > 0) begin
				for (j = 0; j < plen; j++) begin
					text.push_back(vary_case(pat_store[j*8 +: 8], flip));
				end
			end else if (pick < 24 && plen > 1) begin
				cut = $urandom_range(1, plen - 1);
				for (j = 0; j < cut; j++) begin
					text.push_back(vary_case(pat_store[j*8 +: 8], flip));
				end
			end else if (plen > 0 && pick < 70) begin
				text.push_back(vary_case(pat_store[$urandom_range(plen - 1)*8 +: 8], flip));
			end else begin
				text.push_back(vary_case(8'("a" + $urandom_range(3)), flip));
			end
		end
		ending = $urandom_range(99);
		if (ending < 5) begin
			if (text.size() == 0) begin
				text.push_back("z");
			end
		end else begin
			text.push_back(NEWLINE_BYTE);
		end
		for (i = 0; i < text.size(); i++) begin
			send_byte(text[i], ending < 10 && i == text.size() - 1);
		end
		return text.size();
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, value);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input int plen, input bit fold, input bit inv, input bit raw);
		logic [255:0] pat;
		logic [7:0]   b;
		int           k;
		for (k = 0; k < PAT_MAX; k++) begin
			if (raw) begin
				b = 8'($urandom_range(255));
			end else begin
				b = 8'("a" + $urandom_range(3));
				if ($urandom_range(1) == 1) begin
					b = b - 8'h20;
				end
			end
			pat[k*8 +: 8] = b;
		end
		write_reg(REG_PAT_LO,     pat[63:0]);
		write_reg(REG_PAT_MID_LO, pat[127:64]);
		write_reg(REG_PAT_MID_HI, pat[191:128]);
		write_reg(REG_PAT_HI,     pat[255:192]);
		write_reg(REG_PAT_LEN,    64'(plen));
		write_reg(REG_FOLD_CASE,  64'(fold));
		write_reg(REG_INVERT,     64'(inv));
	endtask

	// Holds off until every queued byte has gone in and every line has come out,
	// then lets the pipeline empty before anything is reconfigured.
	task automatic drain();
		do @(posedge clk); while (pending_items.size() != 0 || in_valid ||
				expected_lines.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			data_byte   <= '0;
			end_of_file <= 1'b0;
		end else begin
			// A word is taken when valid and ready are both high.
			if (in_valid && in_ready) begin
				track_byte(data_byte, end_of_file);
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 6)) begin
					in_valid    <= 1'b1;
					data_byte   <= pending_items[0].value;
					end_of_file <= pending_items[0].eof;
					void'(pending_items.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_lines.size() == 0) begin
					$display("%0t: unexpected line, got number %0d length %0d selected %0d",
						$time, line_number, line_length, selected);
					error_count++;
				end else begin
					head_line = expected_lines.pop_front();
					if (line_number !== head_line.num) begin
						$display("%0t: line_number expected %0d, got %0d",
							$time, head_line.num, line_number);
						error_count++;
					end
					if (line_length !== head_line.len) begin
						$display("%0t: line_length expected %0d, got %0d",
							$time, head_line.len, line_length);
						error_count++;
					end
					if (selected !== head_line.sel) begin
						$display("%0t: selected expected %0d, got %0d",
							$time, head_line.sel, selected);
						error_count++;
					end
				end
			end
			out_ready <= no_idle || $urandom_range(99) >= 6;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int p;
		int i;
		int added;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pattern "ab", no folding, no inversion; the unused bytes at both extremes.
		write_reg(REG_PAT_LO,     64'h6261);
		write_reg(REG_PAT_MID_LO, 64'h0);
		write_reg(REG_PAT_MID_HI, 64'h0);
		write_reg(REG_PAT_HI,     '1);
		write_reg(REG_PAT_LEN,    64'd2);
		write_reg(REG_FOLD_CASE,  64'd0);
		write_reg(REG_INVERT,     64'd0);
		send_text("xab\n", 1'b0);
		send_text("AB\n", 1'b0);
		send_text("\n", 1'b0);
		// A NUL hides the rest of the line from the search.
		send_byte("a", 1'b0);
		send_byte(NUL_BYTE, 1'b0);
		send_text("ab\n", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_text("\n", 1'b0);
		send_text("ab\n", 1'b1);
		send_text("ab", 1'b1);
		drain();

		for (p = 0; p < 8; p++) begin
			case (p)
				0: set_config(0, 1'b0, 1'b0, 1'b0);
				1: set_config(1, 1'b0, 1'b0, 1'b0);
				2: set_config(3, 1'b1, 1'b0, 1'b0);
				3: set_config(5, 1'b0, 1'b1, 1'b0);
				4: set_config(32, 1'b1, 1'b0, 1'b0);
				5: set_config(63, 1'b0, 1'b1, 1'b0);
				6: set_config($urandom_range(1, 4), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b1);
				default: set_config($urandom_range(1, 6), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b0);
			endcase
			no_idle = (p == 7);
			added = 0;
			while (added < PHASE_BYTES) begin
				added += queue_line();
			end
			drain();
		end
		no_idle = 1'b0;

		// Lines beyond the storage limit: the tail is dropped, but its newline still ends the line.
		set_config(4, 1'b0, 1'b0, 1'b0);
		for (i = 0; i < 4100; i++) begin
			send_byte((i >= 4093 && i < 4097) ? pat_store[(i-4093)*8 +: 8] : 8'("q"), 1'b0);
		end
		send_byte(NEWLINE_BYTE, 1'b0);
		for (i = 0; i < 4200; i++) begin
			send_byte((i >= 10 && i < 14) ? pat_store[(i-10)*8 +: 8] : 8'("q"), 1'b0);
		end
		send_byte(NEWLINE_BYTE, 1'b1);
		for (i = 0; i < 6; i++) begin
			void'(queue_line());
		end
		drain();

		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
